[src/ryuv_pkg.sv]
`default_nettype none
package ryuv_pkg;

	// Pixel and result field widths
	localparam int PIX_W = 8;
	localparam int CFG_W = 13;
	localparam int IDX_W = 1;

	// Register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	// Frame size defaults and limits
	localparam int DEF_MAX_WIDTH    = 4096;
	localparam int DEF_MAX_HEIGHT   = 4096;
	localparam int RST_FRAME_WIDTH  = 1920;
	localparam int RST_FRAME_HEIGHT = 1080;
	localparam int MIN_WIDTH        = 2;
	localparam int MIN_HEIGHT       = 1;

	// Signed accumulator width for the weighted sums
	localparam int SUM_W = 18;

	// BT.601 studio-range coefficients (scaled by 256)
	localparam logic signed [SUM_W-1:0] Y_R  = 18'sd66;
	localparam logic signed [SUM_W-1:0] Y_G  = 18'sd129;
	localparam logic signed [SUM_W-1:0] Y_B  = 18'sd25;
	localparam logic signed [SUM_W-1:0] CB_R = -18'sd38;
	localparam logic signed [SUM_W-1:0] CB_G = -18'sd74;
	localparam logic signed [SUM_W-1:0] CB_B = 18'sd112;
	localparam logic signed [SUM_W-1:0] CR_R = 18'sd112;
	localparam logic signed [SUM_W-1:0] CR_G = -18'sd94;
	localparam logic signed [SUM_W-1:0] CR_B = -18'sd18;
	localparam logic [PIX_W-1:0]        Y_OFFSET = 8'd16;
	// Chroma offset 128 applied before the shift
	localparam logic signed [SUM_W-1:0] C_BIAS = 18'sd32768;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pix_t;

	typedef struct packed {
		logic chroma_valid;
		logic frame_end;
	} pos_flags_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic [PIX_W-1:0] chroma_blue;
		logic [PIX_W-1:0] chroma_red;
		logic             chroma_valid;
		logic             frame_end;
	} yuv_t;

	// Saturate a dimension to lo..hi and return it minus one
	function automatic int clamp_last(int v, int lo, int hi);
		int c;
		begin
			c = v;
			if (c < lo) c = lo;
			if (c > hi) c = hi;
			return c - 1;
		end
	endfunction

endpackage
`default_nettype wire

[src/ryuv_pix_if.sv]
`default_nettype none
interface ryuv_pix_if import ryuv_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] blue;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] red;

	modport source (output valid, output blue, output green, output red, input ready);
	modport sink (input valid, input blue, input green, input red, output ready);
endinterface
`default_nettype wire

[src/ryuv_yuv_if.sv]
`default_nettype none
interface ryuv_yuv_if import ryuv_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] luma;
	logic [PIX_W-1:0] chroma_blue;
	logic [PIX_W-1:0] chroma_red;
	logic             chroma_valid;
	logic             frame_end;

	modport source (output valid, output luma, output chroma_blue, output chroma_red,
		output chroma_valid, output frame_end, input ready);
	modport sink (input valid, input luma, input chroma_blue, input chroma_red,
		input chroma_valid, input frame_end, output ready);
endinterface
`default_nettype wire

[src/rgb_to_yuv420_converter.sv]
`default_nettype none
// RGB to YUV 4:2:0 converter, BT.601 studio range.
// pix_in takes one pixel word (blue, green, red) in raster order; yuv_out gives one
// word per pixel: luma always, chroma_blue/chroma_red with chroma_valid set at even
// rows and even columns (zero elsewhere), and frame_end on the last pixel of a frame.
// The cfg port writes frame_width (index 0) and frame_height (index 1) on any cycle
// with cfg_wr_en high; values are saturated to the supported range when written.
// Change them only while the block is empty.
// The accepting edge loads the input register (stage 1); the result register (stage 2)
// that drives yuv_out loads from it when stage 2 is empty or being drained.
// Throughput: one pixel per clock while the receiver does not stall; the conversion is
// constant-coefficient multiply-adds between the two registers.
// A stalled receiver holds the result register; the input register keeps accepting
// until both stages are full, then pix_in.ready drops. Nothing is dropped.
// Reset clears both stages, the column and row position and loads 1920x1080.
module rgb_to_yuv420_converter import ryuv_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	ryuv_pix_if.sink              pix_in,
	ryuv_yuv_if.source            yuv_out
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam logic [COL_W-1:0] RST_COL_LAST =
		COL_W'(clamp_last(RST_FRAME_WIDTH, MIN_WIDTH, MAX_WIDTH));
	localparam logic [ROW_W-1:0] RST_ROW_LAST =
		ROW_W'(clamp_last(RST_FRAME_HEIGHT, MIN_HEIGHT, MAX_HEIGHT));

	logic [COL_W-1:0] col_last_q;
	logic [ROW_W-1:0] row_last_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [31:0]      wdata_ext;

	logic       valid_s1;
	logic       valid_s2;
	pix_t       pix_s1;
	pos_flags_t flags_s1;
	yuv_t       res_s2;
	yuv_t       res;
	logic       accept;
	logic       adv_s1;
	logic       line_end;
	logic       frame_end;

	assign wdata_ext = 32'(cfg_wdata);

	// Store saturated frame size as last column / last row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= RST_COL_LAST;
			row_last_q <= RST_ROW_LAST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					if (wdata_ext < 32'(MIN_WIDTH))
						col_last_q <= COL_W'(MIN_WIDTH - 1);
					else if (wdata_ext > 32'(MAX_WIDTH))
						col_last_q <= COL_W'(MAX_WIDTH - 1);
					else
						col_last_q <= COL_W'(wdata_ext - 32'd1);
				end
				REG_FRAME_HEIGHT: begin
					if (wdata_ext < 32'(MIN_HEIGHT))
						row_last_q <= ROW_W'(MIN_HEIGHT - 1);
					else if (wdata_ext > 32'(MAX_HEIGHT))
						row_last_q <= ROW_W'(MAX_HEIGHT - 1);
					else
						row_last_q <= ROW_W'(wdata_ext - 32'd1);
				end
				default: begin
				end
			endcase
		end
	end

	// Pipeline flow: stage 1 moves on when stage 2 is empty or being drained
	assign adv_s1       = valid_s1 && (!valid_s2 || yuv_out.ready);
	assign pix_in.ready = !valid_s1 || adv_s1;
	assign accept       = pix_in.valid && pix_in.ready;

	// Position of the incoming word
	assign line_end  = (col_q >= col_last_q);
	assign frame_end = line_end && (row_q >= row_last_q);

	// Advance column and row on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				col_q <= '0;
				if (frame_end)
					row_q <= '0;
				else
					row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Stage 1: hold the pixel and its position flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1.blue            <= pix_in.blue;
			pix_s1.green           <= pix_in.green;
			pix_s1.red             <= pix_in.red;
			flags_s1.chroma_valid  <= !col_q[0] && !row_q[0];
			flags_s1.frame_end     <= frame_end;
		end
	end

	ryuv_csc u_csc (
		.pix   (pix_s1),
		.flags (flags_s1),
		.res   (res)
	);

	// Stage 2: result register, held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || yuv_out.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_s2 <= res;
	end

	assign yuv_out.valid        = valid_s2;
	assign yuv_out.luma         = res_s2.luma;
	assign yuv_out.chroma_blue  = res_s2.chroma_blue;
	assign yuv_out.chroma_red   = res_s2.chroma_red;
	assign yuv_out.chroma_valid = res_s2.chroma_valid;
	assign yuv_out.frame_end    = res_s2.frame_end;

endmodule
`default_nettype wire

[src/ryuv_csc.sv]
`default_nettype none
module ryuv_csc import ryuv_pkg::*; (
	input  pix_t       pix,
	input  pos_flags_t flags,
	output yuv_t       res
);

	logic signed [SUM_W-1:0] r_s;
	logic signed [SUM_W-1:0] g_s;
	logic signed [SUM_W-1:0] b_s;
	logic signed [SUM_W-1:0] y_sum;
	logic signed [SUM_W-1:0] cb_sum;
	logic signed [SUM_W-1:0] cr_sum;

	// Widen components to the signed accumulator width
	assign r_s = $signed({{(SUM_W-PIX_W){1'b0}}, pix.red});
	assign g_s = $signed({{(SUM_W-PIX_W){1'b0}}, pix.green});
	assign b_s = $signed({{(SUM_W-PIX_W){1'b0}}, pix.blue});

	// Weighted sums, chroma offset folded in before the shift
	assign y_sum  = Y_R * r_s + Y_G * g_s + Y_B * b_s;
	assign cb_sum = CB_R * r_s + CB_G * g_s + CB_B * b_s + C_BIAS;
	assign cr_sum = CR_R * r_s + CR_G * g_s + CR_B * b_s + C_BIAS;

	// Shift right by 8, add luma offset; zero chroma off the sampling grid
	always_comb begin
		res.luma         = y_sum[15:8] + Y_OFFSET;
		res.chroma_blue  = flags.chroma_valid ? cb_sum[15:8] : '0;
		res.chroma_red   = flags.chroma_valid ? cr_sum[15:8] : '0;
		res.chroma_valid = flags.chroma_valid;
		res.frame_end    = flags.frame_end;
	end

endmodule
`default_nettype wire
